### sv/bce_pkg.sv
// ============================================================================
// bce_pkg: shared types and constants of the betweenness centrality engine
// Widths, item and register codes, sequencer states and the interface
// structures of the shared multiply-divide unit.
// ============================================================================
package bce_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int SIGMA_W   = 32;
  localparam int SCORE_W   = 48;
  localparam int DIST_W    = COUNT_W;
  localparam int DB_W      = SCORE_W + 1;
  localparam int CFG_W     = COUNT_W;

  localparam logic [SIGMA_W-1:0] SIGMA_MAX = {SIGMA_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT   = 2'd0,
    CFG_SOURCE_FIRST = 2'd1,
    CFG_SOURCE_STOP  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_RD_OUT,
    ST_DONE,
    ST_SRC_CHK,
    ST_SRC_INIT,
    ST_BFS_POP,
    ST_BFS_V,
    ST_BFS_VDAT,
    ST_BFS_SCAN,
    ST_BFS_UPD,
    ST_BWD_POP,
    ST_BWD_W,
    ST_BWD_WDAT,
    ST_BWD_SCAN,
    ST_BWD_CHK,
    ST_BWD_DIV,
    ST_BWD_CENT,
    ST_BWD_CWR
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic               start;
    logic [SIGMA_W-1:0] a;
    logic [DB_W-1:0]    b;
    logic [SIGMA_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] q;
  } md_rsp_t;

endpackage

### sv/bce_ram.sv
// ============================================================================
// bce_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module bce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bce_muldiv.sv
// ============================================================================
// bce_muldiv: iterative multiply-divide unit
// Computes floor(a*b/c) clamped to the score width, with one shift-add step
// per cycle for the product and one restoring division step per cycle.
// ============================================================================
module bce_muldiv import bce_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam int PROD_W = SIGMA_W + DB_W;
  localparam int STEP_W = $clog2(PROD_W);

  md_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [SIGMA_W-1:0] a_r, a_nxt;
  logic [DB_W-1:0]    b_r, b_nxt;
  logic [SIGMA_W-1:0] c_r, c_nxt;
  logic [PROD_W-1:0]  p_r, p_nxt;
  logic [PROD_W-1:0]  q_r, q_nxt;
  logic [SIGMA_W-1:0] rem_r, rem_nxt;
  logic [SIGMA_W:0]   rem_sh;
  logic               q_bit;

  assign rem_sh = {rem_r, p_r[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, c_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == STEP_W'(SIGMA_W - 1)) state_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == STEP_W'(PROD_W - 1)) state_nxt = MD_DONE;
      MD_DONE: state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    c_nxt   = c_r;
    p_nxt   = p_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    unique case (state_r)
      MD_IDLE: begin
        a_nxt   = req.a;
        b_nxt   = req.b;
        c_nxt   = req.c;
        p_nxt   = '0;
        q_nxt   = '0;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      MD_MUL: begin
        p_nxt   = {p_r[PROD_W-2:0], 1'b0}
                  + (a_r[SIGMA_W-1] ? PROD_W'(b_r) : '0);
        a_nxt   = {a_r[SIGMA_W-2:0], 1'b0};
        cnt_nxt = (cnt_r == STEP_W'(SIGMA_W - 1)) ? '0 : cnt_r + 1'b1;
      end
      MD_DIV: begin
        rem_nxt = q_bit ? SIGMA_W'(rem_sh - {1'b0, c_r}) : SIGMA_W'(rem_sh);
        q_nxt   = {q_r[PROD_W-2:0], q_bit};
        p_nxt   = {p_r[PROD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
      end
      MD_DONE: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  assign rsp.done = (state_r == MD_DONE);
  assign rsp.q    = (|q_r[PROD_W-1:SCORE_W]) ? SCORE_MAX : q_r[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

endmodule

### sv/betweenness_centrality_engine_core.sv
// ============================================================================
// betweenness_centrality_engine_core: Brandes betweenness centrality engine
// Holds a directed graph as an adjacency bitmap and accumulates fixed-point
// betweenness scores over a configurable range of source nodes.
// ============================================================================
// Each transaction gives exactly one result, shown for one cycle with
// out_valid high, and the receiver must take it then. A run walks every
// source of the configured range in turn: per source, the breadth-first
// search pops each reached node and scans its adjacency row bit by bit,
// and the reverse pass scans every node once per reached node; each
// shortest-path dependency term goes through the shared multiply-divide
// unit, which sets the run time on dense graphs. The block holds busy
// high until the result has been shown.
module betweenness_centrality_engine_core import bce_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [NODE_W-1:0]  in_from_node,
  input  logic [NODE_W-1:0]  in_to_node,
  output logic               out_valid,
  output logic [SCORE_W-1:0] out_score,
  output logic               out_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]   nc_r, nc_nxt;
  logic [NODE_W-1:0]    sf_r, sf_nxt;
  logic [COUNT_W-1:0]   ss_r, ss_nxt;
  logic [COUNT_W-1:0]   n_r, n_nxt;
  logic [COUNT_W-1:0]   stop_r, stop_nxt;
  logic [COUNT_W-1:0]   s_r, s_nxt;
  logic [NODE_W-1:0]    from_r, from_nxt;
  logic [NODE_W-1:0]    to_r, to_nxt;
  logic [COUNT_W-1:0]   head_r, head_nxt;
  logic [COUNT_W-1:0]   tail_r, tail_nxt;
  logic [COUNT_W-1:0]   k_r, k_nxt;
  logic [COUNT_W-1:0]   idx_r, idx_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic [MAX_NODES-1:0] row_r, row_nxt;
  logic [DIST_W-1:0]    dcur_r, dcur_nxt;
  logic [SIGMA_W-1:0]   scur_r, scur_nxt;
  logic [SCORE_W-1:0]   delw_r, delw_nxt;
  logic [SCORE_W-1:0]   delv_r, delv_nxt;
  logic [MAX_NODES-1:0] seen_r, seen_nxt;
  logic [MAX_NODES-1:0] adj_vld_r, adj_vld_nxt;
  logic [MAX_NODES-1:0] cent_vld_r, cent_vld_nxt;
  logic                 sat_r, sat_nxt;
  logic [SCORE_W-1:0]   score_r, score_nxt;

  logic                 accept;
  logic [COUNT_W-1:0]   n_calc;
  logic [COUNT_W-1:0]   stop_calc;

  logic [NODE_W-1:0]    node_ra;
  logic [NODE_W-1:0]    order_ra;
  logic [MAX_NODES-1:0] adj_rd, adj_row, adj_wd;
  logic [DIST_W-1:0]    dist_rd, dist_wd;
  logic [SIGMA_W-1:0]   sigma_rd, sigma_wd;
  logic [SCORE_W-1:0]   delta_rd, delta_wd;
  logic [NODE_W-1:0]    order_rd, order_wd;
  logic [SCORE_W-1:0]   cent_rd, cent_wd;
  logic [NODE_W-1:0]    adj_wa, dist_wa, sigma_wa, delta_wa, order_wa, cent_wa;
  logic                 adj_we, dist_we, sigma_we, delta_we, order_we, cent_we;

  logic                 is_new;
  logic                 bfs_match;
  logic [SIGMA_W:0]     sigma_sum;
  logic                 bwd_qual;
  logic [SCORE_W:0]     delta_sum;
  logic [SCORE_W-1:0]   cent_old;
  logic [SCORE_W:0]     cent_sum;

  md_req_t md_req;
  md_rsp_t md_rsp;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid    = (state_r == ST_DONE);
  assign out_score    = score_r;
  assign out_overflow = sat_r;

  assign n_calc    = (nc_r > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : nc_r;
  assign stop_calc = (ss_r > n_calc) ? n_calc : ss_r;

  assign adj_row   = adj_vld_r[cur_r] ? adj_rd : '0;
  assign is_new    = !seen_r[idx_r[NODE_W-1:0]];
  assign bfs_match = is_new || (dist_rd == dcur_r + 1'b1);
  assign sigma_sum = (is_new ? '0 : {1'b0, sigma_rd}) + {1'b0, scur_r};

  assign bwd_qual  = adj_vld_r[idx_r[NODE_W-1:0]] && adj_rd[cur_r]
                     && (dist_rd + 1'b1 == dcur_r) && (scur_r != '0);
  assign delta_sum = {1'b0, delv_r} + {1'b0, md_rsp.q};
  assign cent_old  = cent_vld_r[cur_r] ? cent_rd : '0;
  assign cent_sum  = {1'b0, cent_old} + {1'b0, delw_r};

  assign md_req.start = (state_r == ST_BWD_CHK) && bwd_qual;
  assign md_req.a     = sigma_rd;
  assign md_req.b     = {1'b0, delw_r} + (DB_W'(1) << FRAC_BITS);
  assign md_req.c     = scur_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_CLEAR: state_nxt = ST_DONE;
            MODE_ADD:   state_nxt = ST_ADD_WR;
            MODE_RUN:   state_nxt = ST_SRC_CHK;
            MODE_READ:  state_nxt = ST_RD_OUT;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD_WR:   state_nxt = ST_DONE;
      ST_RD_OUT:   state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      ST_SRC_CHK:  state_nxt = (s_r < stop_r) ? ST_SRC_INIT : ST_DONE;
      ST_SRC_INIT: state_nxt = ST_BFS_POP;
      ST_BFS_POP:  state_nxt = (head_r < tail_r) ? ST_BFS_V : ST_BWD_POP;
      ST_BFS_V:    state_nxt = ST_BFS_VDAT;
      ST_BFS_VDAT: state_nxt = ST_BFS_SCAN;
      ST_BFS_SCAN: begin
        if (idx_r == n_r) begin
          state_nxt = ST_BFS_POP;
        end else if (row_r[idx_r[NODE_W-1:0]]) begin
          state_nxt = ST_BFS_UPD;
        end
      end
      ST_BFS_UPD:  state_nxt = ST_BFS_SCAN;
      ST_BWD_POP:  state_nxt = (k_r == '0) ? ST_SRC_CHK : ST_BWD_W;
      ST_BWD_W:    state_nxt = ST_BWD_WDAT;
      ST_BWD_WDAT: state_nxt = ST_BWD_SCAN;
      ST_BWD_SCAN: begin
        if (idx_r == n_r) begin
          state_nxt = ST_BWD_CENT;
        end else if (seen_r[idx_r[NODE_W-1:0]]) begin
          state_nxt = ST_BWD_CHK;
        end
      end
      ST_BWD_CHK:  state_nxt = bwd_qual ? ST_BWD_DIV : ST_BWD_SCAN;
      ST_BWD_DIV:  if (md_rsp.done) state_nxt = ST_BWD_SCAN;
      ST_BWD_CENT: state_nxt = (cur_r != s_r[NODE_W-1:0]) ? ST_BWD_CWR : ST_BWD_POP;
      ST_BWD_CWR:  state_nxt = ST_BWD_POP;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    nc_nxt       = nc_r;
    sf_nxt       = sf_r;
    ss_nxt       = ss_r;
    n_nxt        = n_r;
    stop_nxt     = stop_r;
    s_nxt        = s_r;
    from_nxt     = from_r;
    to_nxt       = to_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    row_nxt      = row_r;
    dcur_nxt     = dcur_r;
    scur_nxt     = scur_r;
    delw_nxt     = delw_r;
    delv_nxt     = delv_r;
    seen_nxt     = seen_r;
    adj_vld_nxt  = adj_vld_r;
    cent_vld_nxt = cent_vld_r;
    sat_nxt      = sat_r;
    score_nxt    = score_r;

    node_ra  = '0;
    order_ra = '0;
    adj_we   = 1'b0;
    adj_wa   = from_r;
    adj_wd   = adj_row | (MAX_NODES'(1) << to_r);
    dist_we  = 1'b0;
    dist_wa  = idx_r[NODE_W-1:0];
    dist_wd  = dcur_r + 1'b1;
    sigma_we = 1'b0;
    sigma_wa = idx_r[NODE_W-1:0];
    sigma_wd = sigma_sum[SIGMA_W] ? SIGMA_MAX : sigma_sum[SIGMA_W-1:0];
    delta_we = 1'b0;
    delta_wa = idx_r[NODE_W-1:0];
    delta_wd = '0;
    order_we = 1'b0;
    order_wa = tail_r[NODE_W-1:0];
    order_wd = idx_r[NODE_W-1:0];
    cent_we  = 1'b0;
    cent_wa  = cur_r;
    cent_wd  = cent_sum[SCORE_W] ? SCORE_MAX : cent_sum[SCORE_W-1:0];

    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NODE_COUNT:   nc_nxt = cfg_data;
        CFG_SOURCE_FIRST: sf_nxt = cfg_data[NODE_W-1:0];
        CFG_SOURCE_STOP:  ss_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        node_ra = in_from_node;
        if (accept) begin
          from_nxt  = in_from_node;
          to_nxt    = in_to_node;
          cur_nxt   = in_from_node;
          score_nxt = '0;
          n_nxt     = n_calc;
          stop_nxt  = stop_calc;
          s_nxt     = COUNT_W'(sf_r);
          if (mode_t'(in_mode) == MODE_CLEAR) begin
            adj_vld_nxt  = '0;
            cent_vld_nxt = '0;
            sat_nxt      = 1'b0;
          end
        end
      end
      ST_ADD_WR: begin
        adj_we               = 1'b1;
        adj_vld_nxt[from_r]  = 1'b1;
      end
      ST_RD_OUT: begin
        score_nxt = cent_old;
      end
      ST_SRC_INIT: begin
        seen_nxt   = MAX_NODES'(1) << s_r[NODE_W-1:0];
        dist_we    = 1'b1;
        dist_wa    = s_r[NODE_W-1:0];
        dist_wd    = '0;
        sigma_we   = 1'b1;
        sigma_wa   = s_r[NODE_W-1:0];
        sigma_wd   = SIGMA_W'(1);
        delta_we   = 1'b1;
        delta_wa   = s_r[NODE_W-1:0];
        order_we   = 1'b1;
        order_wa   = '0;
        order_wd   = s_r[NODE_W-1:0];
        tail_nxt   = COUNT_W'(1);
        head_nxt   = '0;
      end
      ST_BFS_POP: begin
        order_ra = head_r[NODE_W-1:0];
        if (head_r < tail_r) begin
          head_nxt = head_r + 1'b1;
        end else begin
          k_nxt = tail_r;
        end
      end
      ST_BFS_V: begin
        node_ra = order_rd;
        cur_nxt = order_rd;
      end
      ST_BFS_VDAT: begin
        row_nxt  = adj_row;
        dcur_nxt = dist_rd;
        scur_nxt = sigma_rd;
        idx_nxt  = '0;
      end
      ST_BFS_SCAN: begin
        node_ra = idx_r[NODE_W-1:0];
        if (idx_r != n_r && !row_r[idx_r[NODE_W-1:0]]) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_BFS_UPD: begin
        if (is_new) begin
          seen_nxt[idx_r[NODE_W-1:0]] = 1'b1;
          dist_we  = 1'b1;
          delta_we = 1'b1;
          if (tail_r < COUNT_W'(MAX_NODES)) begin
            order_we = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
        if (bfs_match) begin
          sigma_we = 1'b1;
          if (sigma_sum[SIGMA_W]) begin
            sat_nxt = 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
      end
      ST_BWD_POP: begin
        order_ra = NODE_W'(k_r - 1'b1);
        if (k_r != '0) begin
          k_nxt = k_r - 1'b1;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ST_BWD_W: begin
        node_ra = order_rd;
        cur_nxt = order_rd;
      end
      ST_BWD_WDAT: begin
        dcur_nxt = dist_rd;
        scur_nxt = sigma_rd;
        delw_nxt = delta_rd;
        idx_nxt  = '0;
      end
      ST_BWD_SCAN: begin
        node_ra = idx_r[NODE_W-1:0];
        if (idx_r != n_r && !seen_r[idx_r[NODE_W-1:0]]) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_BWD_CHK: begin
        delv_nxt = delta_rd;
        if (!bwd_qual) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_BWD_DIV: begin
        if (md_rsp.done) begin
          delta_we = 1'b1;
          delta_wd = delta_sum[SCORE_W] ? SCORE_MAX : delta_sum[SCORE_W-1:0];
          idx_nxt  = idx_r + 1'b1;
        end
      end
      ST_BWD_CENT: begin
        node_ra = cur_r;
      end
      ST_BWD_CWR: begin
        cent_we             = 1'b1;
        cent_vld_nxt[cur_r] = 1'b1;
        if (cent_sum[SCORE_W]) begin
          sat_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      nc_r       <= COUNT_W'(MAX_NODES);
      sf_r       <= '0;
      ss_r       <= COUNT_W'(MAX_NODES);
      adj_vld_r  <= '0;
      cent_vld_r <= '0;
      sat_r      <= 1'b0;
      score_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      nc_r       <= nc_nxt;
      sf_r       <= sf_nxt;
      ss_r       <= ss_nxt;
      adj_vld_r  <= adj_vld_nxt;
      cent_vld_r <= cent_vld_nxt;
      sat_r      <= sat_nxt;
      score_r    <= score_nxt;
    end
    n_r    <= n_nxt;
    stop_r <= stop_nxt;
    s_r    <= s_nxt;
    from_r <= from_nxt;
    to_r   <= to_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
    cur_r  <= cur_nxt;
    row_r  <= row_nxt;
    dcur_r <= dcur_nxt;
    scur_r <= scur_nxt;
    delw_r <= delw_nxt;
    delv_r <= delv_nxt;
    seen_r <= seen_nxt;
  end

  bce_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(node_ra), .rdata(adj_rd)
  );

  bce_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
    .raddr(node_ra), .rdata(dist_rd)
  );

  bce_ram #(.WIDTH(SIGMA_W), .DEPTH(MAX_NODES)) u_sigma (
    .clk(clk), .we(sigma_we), .waddr(sigma_wa), .wdata(sigma_wd),
    .raddr(node_ra), .rdata(sigma_rd)
  );

  bce_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_delta (
    .clk(clk), .we(delta_we), .waddr(delta_wa), .wdata(delta_wd),
    .raddr(node_ra), .rdata(delta_rd)
  );

  bce_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order (
    .clk(clk), .we(order_we), .waddr(order_wa), .wdata(order_wd),
    .raddr(order_ra), .rdata(order_rd)
  );

  bce_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_cent (
    .clk(clk), .we(cent_we), .waddr(cent_wa), .wdata(cent_wd),
    .raddr(node_ra), .rdata(cent_rd)
  );

  bce_muldiv u_muldiv (
    .clk(clk), .rst_n(rst_n), .req(md_req), .rsp(md_rsp)
  );

endmodule

### dv/tb_betweenness_centrality_engine_core.sv
// ============================================================================
// tb_betweenness_centrality_engine_core: self-checking bench for the engine
// A queue-fed driver issues clear, add edge, run and read transactions; a
// monitor predicts each accepted transaction with a local Brandes model in
// fixed point and checks every result strobe against the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb_betweenness_centrality_engine_core;
  import bce_pkg::*;

  typedef struct packed {
    mode_t             mode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } job_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               overflow;
  } answer_t;

  localparam int STALL_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = 2'd0;
  logic [NODE_W-1:0]  in_from_node = '0;
  logic [NODE_W-1:0]  in_to_node = '0;
  logic               out_valid;
  logic [SCORE_W-1:0] out_score;
  logic               out_overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 2'd0;
  logic [CFG_W-1:0]   cfg_data = '0;

  betweenness_centrality_engine_core uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  job_t    pending_jobs[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  int      stall_cycles = 0;
  int      queued = 0;
  bit      steady_send = 1'b0;

  // Local copy of the engine state.
  logic [MAX_NODES-1:0] graph_rows[MAX_NODES];
  logic [SCORE_W-1:0]   scores[MAX_NODES];
  bit                   sat_flag;
  int unsigned          nodes_used = 64;
  int unsigned          src_first = 0;
  int unsigned          src_stop = 64;

  int                   hop[MAX_NODES];
  longint unsigned      paths[MAX_NODES];
  longint unsigned      credit[MAX_NODES];
  int unsigned          bfs_queue[MAX_NODES];

  function automatic logic [SCORE_W-1:0] scaled_ratio(logic [SIGMA_W-1:0] a,
                                                      logic [DB_W-1:0] b,
                                                      logic [SIGMA_W-1:0] c);
    logic [127:0] q;
    q = ({96'd0, a} * {79'd0, b}) / {96'd0, c};
    return (q[127:SCORE_W] != '0) ? SCORE_MAX : q[SCORE_W-1:0];
  endfunction

  task automatic score_source(int unsigned s, int unsigned n);
    logic [MAX_NODES-1:0] seen;
    int unsigned head, tail, v, w;
    longint unsigned sum, d;
    logic [SCORE_W-1:0] term;
    logic [SCORE_W:0] c;
    seen = '0;
    seen[s] = 1'b1;
    hop[s] = 0;
    paths[s] = 1;
    credit[s] = 0;
    bfs_queue[0] = s;
    head = 0;
    tail = 1;
    while (head < tail) begin
      v = bfs_queue[head % MAX_NODES];
      head++;
      for (w = 0; w < n; w++) begin
        if (!graph_rows[v][w]) continue;
        if (!seen[w]) begin
          seen[w] = 1'b1;
          hop[w] = hop[v] + 1;
          paths[w] = 0;
          credit[w] = 0;
          if (tail < MAX_NODES) begin
            bfs_queue[tail] = w;
            tail++;
          end
        end
        if (hop[w] == hop[v] + 1) begin
          sum = paths[w] + paths[v];
          if (sum > SIGMA_MAX) begin
            sum = SIGMA_MAX;
            sat_flag = 1'b1;
          end
          paths[w] = sum;
        end
      end
    end
    for (int k = int'(tail) - 1; k >= 0; k--) begin
      w = bfs_queue[k];
      for (v = 0; v < n; v++) begin
        if (!seen[v] || !graph_rows[v][w]) continue;
        if (hop[v] + 1 != hop[w] || paths[w] == 0) continue;
        term = scaled_ratio(paths[v][SIGMA_W-1:0],
                            DB_W'((64'd1 << FRAC_BITS) + credit[w]),
                            paths[w][SIGMA_W-1:0]);
        d = credit[v] + term;
        credit[v] = (d > SCORE_MAX) ? SCORE_MAX : d;
      end
      if (w != s) begin
        c = {1'b0, scores[w]} + credit[w][SCORE_W-1:0];
        if (c[SCORE_W]) begin
          scores[w] = SCORE_MAX;
          sat_flag = 1'b1;
        end else begin
          scores[w] = c[SCORE_W-1:0];
        end
      end
    end
  endtask

  task automatic predict_job(job_t j, output answer_t ans);
    int unsigned n, stop;
    ans.score = '0;
    case (j.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < MAX_NODES; i++) begin
          graph_rows[i] = '0;
          scores[i] = '0;
        end
        sat_flag = 1'b0;
      end
      MODE_ADD: graph_rows[j.from_node][j.to_node] = 1'b1;
      MODE_RUN: begin
        n = (nodes_used > MAX_NODES) ? MAX_NODES : nodes_used;
        stop = (src_stop > n) ? n : src_stop;
        for (int unsigned s = src_first; s < stop; s++) score_source(s, n);
      end
      default: ans.score = scores[j.from_node];
    endcase
    ans.overflow = sat_flag;
  endtask

  // Driver.
  always @(posedge clk) begin
    bit take;
    take = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (take) void'(pending_jobs.pop_front());
      if (start && !take) begin
      end else if (pending_jobs.size() != 0 &&
                   (steady_send || $urandom_range(99) >= 32)) begin
        start        <= 1'b1;
        in_mode      <= pending_jobs[0].mode;
        in_from_node <= pending_jobs[0].from_node;
        in_to_node   <= pending_jobs[0].to_node;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor.
  always @(posedge clk) begin
    answer_t want, got;
    job_t j;
    if (rst_n) begin
      if (out_valid) begin
        got.score = out_score;
        got.overflow = out_overflow;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: score %0h overflow %0b", out_score, out_overflow);
        end else begin
          want = expected_answers.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected score %0h overflow %0b, got score %0h overflow %0b",
                       want.score, want.overflow, got.score, got.overflow);
          end
        end
      end
      if (start && !busy) begin
        j.mode = mode_t'(in_mode);
        j.from_node = in_from_node;
        j.to_node = in_to_node;
        predict_job(j, want);
        expected_answers.push_back(want);
      end
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_betweenness_centrality_engine_core: errors");
        $finish;
      end
    end
  end

  task automatic queue_job(mode_t m, int a, int b);
    job_t j;
    j.mode = m;
    j.from_node = a[NODE_W-1:0];
    j.to_node = b[NODE_W-1:0];
    pending_jobs.push_back(j);
    queued++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_jobs.size() != 0 || expected_answers.size() != 0 || start || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NODE_COUNT:   nodes_used = val;
      CFG_SOURCE_FIRST: src_first = val[NODE_W-1:0];
      CFG_SOURCE_STOP:  src_stop = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_range(int n, int first, int stop);
    write_reg(CFG_NODE_COUNT, n[CFG_W-1:0]);
    write_reg(CFG_SOURCE_FIRST, first[CFG_W-1:0]);
    write_reg(CFG_SOURCE_STOP, stop[CFG_W-1:0]);
  endtask

  initial begin
    int n, lim, first, stop, r;
    for (int i = 0; i < MAX_NODES; i++) begin
      graph_rows[i] = '0;
      scores[i] = '0;
    end
    sat_flag = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Small graph with a duplicate edge, a self loop and out-of-range edges.
    set_range(6, 0, 6);
    queue_job(MODE_CLEAR, 0, 0);
    queue_job(MODE_ADD, 0, 1);
    queue_job(MODE_ADD, 1, 2);
    queue_job(MODE_ADD, 0, 2);
    queue_job(MODE_ADD, 2, 3);
    queue_job(MODE_ADD, 1, 3);
    queue_job(MODE_ADD, 3, 3);
    queue_job(MODE_ADD, 0, 1);
    queue_job(MODE_ADD, 4, 63);
    queue_job(MODE_ADD, 63, 5);
    queue_job(MODE_RUN, 0, 0);
    for (int i = 0; i < 4; i++) queue_job(MODE_READ, i, 63);
    queue_job(MODE_READ, 63, 0);
    drain();

    // Zero nodes, oversized node count, stop cut back, empty range.
    set_range(0, 0, 6);
    queue_job(MODE_RUN, 0, 0);
    queue_job(MODE_READ, 2, 0);
    drain();
    set_range(127, 0, 2);
    queue_job(MODE_RUN, 0, 0);
    queue_job(MODE_READ, 63, 0);
    drain();
    set_range(6, 5, 100);
    queue_job(MODE_RUN, 0, 0);
    drain();
    set_range(6, 4, 2);
    queue_job(MODE_RUN, 0, 0);
    queue_job(MODE_READ, 3, 0);
    drain();

    // Every source of a full-size graph with a single edge.
    set_range(64, 0, 64);
    queue_job(MODE_CLEAR, 0, 0);
    queue_job(MODE_ADD, 63, 0);
    queue_job(MODE_RUN, 0, 0);
    queue_job(MODE_READ, 0, 0);
    drain();

    // Layered pairs double the path count at each layer.
    set_range(64, 0, 1);
    queue_job(MODE_CLEAR, 0, 0);
    for (int k = 0; k < 62; k += 2)
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++) queue_job(MODE_ADD, k + a, k + 2 + b);
    queue_job(MODE_RUN, 0, 0);
    queue_job(MODE_READ, 2, 0);
    queue_job(MODE_READ, 63, 0);
    queue_job(MODE_CLEAR, 0, 0);
    drain();

    for (int phase = 0; queued < 1300; phase++) begin
      steady_send = (phase >= 8 && phase < 12);
      r = $urandom_range(99);
      if (r < 70) n = $urandom_range(8, 1);
      else if (r < 80) n = 64;
      else if (r < 85) n = $urandom_range(127, 65);
      else n = $urandom_range(16, 9);
      lim = (n > MAX_NODES) ? MAX_NODES : n;
      first = $urandom_range(127);
      if ($urandom_range(3) != 0) first = $urandom_range(lim - 1);
      stop = first + $urandom_range(3);
      if (lim <= 16 && $urandom_range(3) == 0) stop = $urandom_range(127);
      set_range(n, first, stop);
      if ($urandom_range(1) == 0) queue_job(MODE_CLEAR, 0, 0);
      repeat ($urandom_range(10, 3))
        queue_job(MODE_ADD, $urandom_range(lim - 1), $urandom_range(lim - 1));
      queue_job(MODE_RUN, $urandom_range(63), $urandom_range(63));
      repeat (3) queue_job(MODE_READ, $urandom_range(lim - 1), $urandom_range(63));
      repeat (12) begin
        r = $urandom_range(99);
        if (r < 5) queue_job(MODE_CLEAR, $urandom_range(63), $urandom_range(63));
        else if (r < 50)
          queue_job(MODE_ADD, ($urandom_range(4) == 0) ? $urandom_range(63)
                                                       : $urandom_range(lim - 1),
                    ($urandom_range(4) == 0) ? $urandom_range(63)
                                             : $urandom_range(lim - 1));
        else if (r < 58) queue_job(MODE_RUN, $urandom_range(63), $urandom_range(63));
        else queue_job(MODE_READ, $urandom_range(63), $urandom_range(63));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("tb_betweenness_centrality_engine_core: clean");
    else
      $display("tb_betweenness_centrality_engine_core: errors");
    $finish;
  end

endmodule
